@@ rtl/bfik_pkg.sv @@
// ----------------------------------------------------------------------------
// bfik_pkg
// Shared types and constants of the integer-key Bloom filter: field widths,
// register indexes, action codes, hash constants and the control bundles
// that run between the sequencer and the hash unit.
// ----------------------------------------------------------------------------
package bfik_pkg;

    // Field and register widths.
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned HASH_W   = 32;
    localparam int unsigned SEED_W   = 16;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned HCNT_W   = 4;
    localparam int unsigned CCNT_W   = 21;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned OUT_DATA_W = 8;

    // Capacity defaults and limits.
    localparam int unsigned DEF_MAX_CELLS  = 1048576;
    localparam int unsigned MAX_HASHES     = 12;
    localparam int unsigned SEEDS_PER_WORD = WORD_W / SEED_W;
    localparam int unsigned SEED_SLOTS     = 2 ** HCNT_W;

    // Register reset values.
    localparam logic [HCNT_W-1:0] HCNT_RST = HCNT_W'(10);
    localparam logic [CCNT_W-1:0] CCNT_RST = CCNT_W'(1048576);

    // Bit store row geometry: 64 cells per memory row.
    localparam int unsigned ROW_BITS  = 64;
    localparam int unsigned ROW_SHIFT = 6;

    // Mixing constants.
    localparam int unsigned MIX_MUL_W = 27;
    localparam logic [MIX_MUL_W-1:0] MIX_MUL = 27'h45d9f3b;
    localparam int unsigned XS_SHIFT  = 16;

    // Remainder unit: quotient bits retired per cycle.
    localparam int unsigned DIV_STEP   = 4;
    localparam int unsigned DIV_CYCLES = HASH_W / DIV_STEP;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HASH_COUNT  = 3'd0,
        REG_CELL_COUNT  = 3'd1,
        REG_SEED_WORD_0 = 3'd2,
        REG_SEED_WORD_1 = 3'd3,
        REG_SEED_WORD_2 = 3'd4
    } cfg_reg_t;

    // Action codes carried on the input tuser bit.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_HASH,
        SQ_MOD,
        SQ_READ,
        SQ_CHECK,
        SQ_DONE
    } seq_state_t;

    // Hash unit phases.
    typedef enum logic [1:0] {
        HP_IDLE,
        HP_MLO,
        HP_MHI,
        HP_ADD
    } hash_phase_t;

    // Request into the hash unit.
    typedef struct packed {
        logic              start;
        logic [KEY_W-1:0]  key;
        logic [SEED_W-1:0] seed;
    } hash_req_t;

    // Response from the hash unit.
    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] hash;
    } hash_rsp_t;

endpackage

@@ rtl/bfik_hash.sv @@
// ----------------------------------------------------------------------------
// bfik_hash
// Seeded 64-bit mixer: two xorshift-multiply rounds and a final xorshift.
// The 64 x 27 bit product is built from two 32 x 27 partial products on one
// shared multiplier.
// ----------------------------------------------------------------------------
module bfik_hash (
    input  logic                aclk,
    input  logic                aresetn,
    input  bfik_pkg::hash_req_t req,
    output bfik_pkg::hash_rsp_t rsp
);
    import bfik_pkg::*;

    localparam int unsigned PROD_W = HASH_W + MIX_MUL_W;

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
        return v ^ (v >> XS_SHIFT);
    endfunction

    hash_phase_t        phase_reg, phase_next;
    logic               round_reg;
    logic               done_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic [WORD_W-1:0]  x_reg;
    logic [PROD_W-1:0]  plo_reg;
    logic [HASH_W-1:0]  phi_reg;

    logic [HASH_W-1:0]  mul_a;
    logic [PROD_W-1:0]  prod;
    logic [WORD_W-1:0]  v_sum;
    logic [WORD_W-1:0]  x_new;
    logic [WORD_W-1:0]  x_init;
    logic               last_add;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            HP_IDLE: if (req.start) phase_next = HP_MLO;
            HP_MLO:  phase_next = HP_MHI;
            HP_MHI:  phase_next = HP_ADD;
            HP_ADD:  phase_next = round_reg ? HP_IDLE : HP_MLO;
            default: phase_next = HP_IDLE;
        endcase
    end

    // Datapath controls: operand select and the end of the second round.
    always_comb begin
        mul_a    = x_reg[HASH_W-1:0];
        last_add = 1'b0;
        unique case (phase_reg)
            HP_MHI:  mul_a = x_reg[WORD_W-1:HASH_W];
            HP_ADD:  last_add = round_reg;
            default: mul_a = x_reg[HASH_W-1:0];
        endcase
    end

    // Shared multiplier and the recombination of the partial products.
    assign prod   = PROD_W'(mul_a) * PROD_W'(MIX_MUL);
    assign v_sum  = WORD_W'(plo_reg) + {phi_reg, {HASH_W{1'b0}}};
    assign x_new  = xorshift(v_sum);
    assign x_init = xorshift({req.key, {(WORD_W-KEY_W-SEED_W){1'b0}}, req.seed});

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= HP_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= last_add;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (phase_reg == HP_IDLE && req.start) begin
            x_reg     <= x_init;
            round_reg <= 1'b0;
        end
        if (phase_reg == HP_MLO) begin
            plo_reg <= prod;
        end
        if (phase_reg == HP_MHI) begin
            phi_reg <= prod[HASH_W-1:0];
        end
        if (phase_reg == HP_ADD) begin
            x_reg     <= x_new;
            round_reg <= 1'b1;
        end
        if (last_add) begin
            hash_reg <= x_new[HASH_W-1:0];
        end
    end

    // Response bundle.
    always_comb begin
        rsp.done = done_reg;
        rsp.hash = hash_reg;
    end

endmodule

@@ rtl/bfik_mod.sv @@
// ----------------------------------------------------------------------------
// bfik_mod
// Remainder unit: hash modulo cell count by restoring division, retiring
// DIV_STEP dividend bits per cycle. Only the remainder is kept.
// ----------------------------------------------------------------------------
module bfik_mod #(
    parameter int unsigned NC_W = 21
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bfik_pkg::HASH_W-1:0] dividend,
    input  logic [NC_W-1:0]             divisor,
    output logic                        done,
    output logic [NC_W-1:0]             rem
);
    import bfik_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_CYCLES + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [HASH_W-1:0] dvd_reg;
    logic [NC_W-1:0]   dsr_reg;
    logic [NC_W-1:0]   rem_reg;
    logic [NC_W-1:0]   rem_next;

    // Several restoring steps per cycle; the partial remainder stays below
    // the divisor, so one compare and subtract per bit suffices.
    always_comb begin
        logic [NC_W:0]   trial;
        logic [NC_W-1:0] r;
        r = rem_reg;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {r, dvd_reg[HASH_W-1-k]};
            if (trial >= {1'b0, dsr_reg}) begin
                trial = trial - {1'b0, dsr_reg};
            end
            r = trial[NC_W-1:0];
        end
        rem_next = r;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_CYCLES);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << DIV_STEP;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/bfik_store.sv @@
// ----------------------------------------------------------------------------
// bfik_store
// Bit store: a single-port-write, registered-read memory of 64-bit rows.
// After reset a clearing pass zeroes one row per cycle and holds busy high.
// ----------------------------------------------------------------------------
module bfik_store #(
    parameter int unsigned ROWS = 16384
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          busy,
    input  logic                          rd_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row,
    output logic [bfik_pkg::ROW_BITS-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_row,
    input  logic [bfik_pkg::ROW_BITS-1:0] wr_data
);
    import bfik_pkg::*;

    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                clr_active_reg;
    logic [ROW_W-1:0]    clr_row_reg;

    logic                we;
    logic [ROW_W-1:0]    waddr;
    logic [ROW_BITS-1:0] wdata;

    // The clearing pass owns the write port until it is done.
    assign we    = clr_active_reg | wr_en;
    assign waddr = clr_active_reg ? clr_row_reg : wr_row;
    assign wdata = clr_active_reg ? '0 : wr_data;

    // Clearing pass control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end else if (clr_active_reg) begin
            if (clr_row_reg == ROW_W'(ROWS - 1)) begin
                clr_active_reg <= 1'b0;
            end else begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            end
        end
    end

    // Memory array with registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign busy    = clr_active_reg;
    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bloom_filter_int_keys.sv @@
// Processing: each hash of a key passes the shared mixer multiplier, the
// 4-bit-per-cycle remainder unit and a row read and check, with a write-back
// on insert; a search stops at the first clear cell.
// Throughput: one key at a time; the next is accepted when this one is done.
// Reset: synchronous, active low; then the bit store is cleared one row per
// cycle over all ROWS rows (16384 by default) while s_tready stays low.
// ----------------------------------------------------------------------------
// bloom_filter_int_keys
// Bloom filter over 32-bit keys: insert sets the seeded hash cells, search
// reports whether all of them are set.
// ----------------------------------------------------------------------------
module bloom_filter_int_keys #(
    parameter int unsigned MAX_CELLS = bfik_pkg::DEF_MAX_CELLS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input transfers.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bfik_pkg::KEY_W-1:0]       s_tdata,   // key
    input  logic                             s_tuser,   // action
    // Result transfers.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bfik_pkg::OUT_DATA_W-1:0]  m_tdata,   // present, then zero fill
    // Configuration writes.
    input  logic                             cfg_wr_en,
    input  logic [bfik_pkg::CFG_IDX_W-1:0]   cfg_wr_idx,
    input  logic [bfik_pkg::WORD_W-1:0]      cfg_wr_data
);
    import bfik_pkg::*;

    localparam int unsigned ROWS  = (MAX_CELLS + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned NC_W  = $clog2(MAX_CELLS + 1);

    // Configuration registers.
    logic [HCNT_W-1:0] hcnt_reg;
    logic [CCNT_W-1:0] ccnt_reg;
    logic [WORD_W-1:0] seed_word_reg [3];

    // Sequencer and item registers.
    seq_state_t        state_reg, state_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              present_reg;
    logic              action_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [HCNT_W-1:0] idx_reg;
    logic              all_set_reg;
    logic [NC_W-1:0]   cell_reg;

    logic [SEED_W-1:0] seed_tab [SEED_SLOTS];
    logic [HCNT_W-1:0] nh_eff;
    logic [NC_W-1:0]   nc_eff;
    logic [HCNT_W-1:0] seed_idx;
    logic              in_xfer;
    logic              last_hash;
    logic              cell_bit;
    logic              load_out;

    hash_req_t         hash_req;
    hash_rsp_t         hash_rsp;
    logic              mod_done;
    logic [NC_W-1:0]   mod_rem;

    logic              st_busy;
    logic              st_rd_en;
    logic              st_wr_en;
    logic [ROW_W-1:0]  st_row;
    logic [ROW_BITS-1:0] st_rd_data;
    logic [ROW_BITS-1:0] st_wr_data;

    // Seed table: sixteen bits per seed, four seeds per word.
    for (genvar g = 0; g < SEED_SLOTS; g++) begin : g_seed
        if (g < MAX_HASHES) begin : g_used
            assign seed_tab[g] =
                seed_word_reg[g / SEEDS_PER_WORD][(g % SEEDS_PER_WORD) * SEED_W +: SEED_W];
        end else begin : g_unused
            assign seed_tab[g] = '0;
        end
    end

    // Effective hash count and cell count after saturation; a cell count of zero is taken as one.
    assign nh_eff = (hcnt_reg > HCNT_W'(MAX_HASHES)) ? HCNT_W'(MAX_HASHES) : hcnt_reg;

    always_comb begin
        if (ccnt_reg == '0) begin
            nc_eff = NC_W'(1);
        end else if (32'(ccnt_reg) > 32'(MAX_CELLS)) begin
            nc_eff = NC_W'(MAX_CELLS);
        end else begin
            nc_eff = NC_W'(ccnt_reg);
        end
    end

    assign s_tready  = (state_reg == SQ_IDLE) && !st_busy;
    assign in_xfer   = s_tvalid && s_tready;
    assign last_hash = (idx_reg == nh_eff - HCNT_W'(1));
    assign st_row    = ROW_W'(cell_reg >> ROW_SHIFT);
    assign cell_bit  = st_rd_data[cell_reg[ROW_SHIFT-1:0]];

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE: begin
                if (in_xfer) begin
                    state_next = (nh_eff == '0) ? SQ_DONE : SQ_HASH;
                end
            end
            SQ_HASH:  if (hash_rsp.done) state_next = SQ_MOD;
            SQ_MOD:   if (mod_done) state_next = SQ_READ;
            SQ_READ:  state_next = SQ_CHECK;
            SQ_CHECK: begin
                if ((action_reg == ACT_SEARCH && !cell_bit) || last_hash) begin
                    state_next = SQ_DONE;
                end else begin
                    state_next = SQ_HASH;
                end
            end
            SQ_DONE: begin
                if (action_reg == ACT_INSERT || !m_tvalid_reg || m_tready) begin
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    // Sequencer outputs: hash starts, memory accesses and result loading.
    always_comb begin
        hash_req.start = 1'b0;
        hash_req.key   = key_reg;
        seed_idx       = idx_reg + HCNT_W'(1);
        st_rd_en       = 1'b0;
        st_wr_en       = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            SQ_IDLE: begin
                hash_req.start = in_xfer && (nh_eff != '0);
                hash_req.key   = s_tdata;
                seed_idx       = '0;
            end
            SQ_READ:  st_rd_en = 1'b1;
            SQ_CHECK: begin
                st_wr_en       = (action_reg == ACT_INSERT);
                hash_req.start = !((action_reg == ACT_SEARCH && !cell_bit) || last_hash);
            end
            SQ_DONE: begin
                load_out = (action_reg == ACT_SEARCH) && (!m_tvalid_reg || m_tready);
            end
            default: ;
        endcase
        hash_req.seed = seed_tab[seed_idx];
    end

    assign st_wr_data    = st_rd_data | (ROW_BITS'(1) << cell_reg[ROW_SHIFT-1:0]);

    // Output register: a waiting result does not block the next input.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= SQ_IDLE;
            m_tvalid_reg     <= 1'b0;
            hcnt_reg         <= HCNT_RST;
            ccnt_reg         <= CCNT_RST;
            seed_word_reg[0] <= '0;
            seed_word_reg[1] <= '0;
            seed_word_reg[2] <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_wr_idx)
                    REG_HASH_COUNT:  hcnt_reg         <= cfg_wr_data[HCNT_W-1:0];
                    REG_CELL_COUNT:  ccnt_reg         <= cfg_wr_data[CCNT_W-1:0];
                    REG_SEED_WORD_0: seed_word_reg[0] <= cfg_wr_data;
                    REG_SEED_WORD_1: seed_word_reg[1] <= cfg_wr_data;
                    REG_SEED_WORD_2: seed_word_reg[2] <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    // Item registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            action_reg  <= s_tuser;
            key_reg     <= s_tdata;
            idx_reg     <= '0;
            all_set_reg <= 1'b1;
        end else if (state_reg == SQ_CHECK) begin
            if (action_reg == ACT_SEARCH && !cell_bit) begin
                all_set_reg <= 1'b0;
            end
            idx_reg <= idx_reg + HCNT_W'(1);
        end
        if (mod_done) begin
            cell_reg <= mod_rem;
        end
        if (load_out) begin
            present_reg <= all_set_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(present_reg);

    // Seeded mixer.
    bfik_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hash_req),
        .rsp     (hash_rsp)
    );

    // Hash modulo the cell count.
    bfik_mod #(
        .NC_W (NC_W)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (hash_rsp.done),
        .dividend (hash_rsp.hash),
        .divisor  (nc_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Bit store. Each row read-modify-write finishes in the check cycle,
    // long before the next read, so accesses never overlap.
    bfik_store #(
        .ROWS (ROWS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .busy    (st_busy),
        .rd_en   (st_rd_en),
        .rd_row  (st_row),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_row  (st_row),
        .wr_data (st_wr_data)
    );

    // A finished hash must land while the sequencer waits for it.
    a_hash_in_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_rsp.done |-> state_reg == SQ_HASH)
        else $error("hash result outside the hash wait state");

    // The remainder always addresses a cell in use.
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> mod_rem < nc_eff)
        else $error("remainder not below the cell count");

    // Inserts never race the clearing pass.
    a_no_wr_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        st_wr_en |-> !st_busy)
        else $error("bit store write during clearing pass");

    // Only searches produce results.
    a_out_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(action_reg == ACT_SEARCH))
        else $error("result produced by an insert");

endmodule
